/* rtl/cddo_pkg.sv */
// cddo_pkg: shared types, constants and calendar functions for the date offset unit
// used by cddo_step_unit, calendar_date_day_offset_unit and cddo_checker
// no dependencies
package cddo_pkg;

	// field widths
	localparam int unsigned DAY_W    = 5;
	localparam int unsigned MONTH_W  = 4;
	localparam int unsigned YEAR_W   = 14;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned STATUS_W = 2;

	// internal working widths: walked year and day count may go negative
	localparam int unsigned WYEAR_W = YEAR_W + 2;
	localparam int unsigned WDAY_W  = OFFSET_W + 1;
	localparam int unsigned CENT_W  = 8;
	localparam int unsigned REM_W   = 7;

	// stream payload widths
	localparam int unsigned S_TDATA_W = 40;
	localparam int unsigned M_TDATA_W = 24;

	// configuration register indexes and reset values
	localparam logic CFG_MIN_YEAR = 1'b0;
	localparam logic CFG_MAX_YEAR = 1'b1;
	localparam logic [YEAR_W-1:0] MIN_YEAR_RST = 14'd1902;
	localparam logic [YEAR_W-1:0] MAX_YEAR_RST = 14'd2037;

	// calendar constants
	localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
	localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
	localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
	localparam logic [DAY_W-1:0]   LEAP_FEB_DAYS = 5'd29;
	localparam logic [REM_W-1:0]   REM_MAX = 7'd99;

	// year / 100 by reciprocal: (y * 5243) >> 19 is exact for every 14-bit year
	localparam int unsigned          RECIP_W     = 13;
	localparam logic [RECIP_W-1:0]   RECIP_100   = 13'd5243;
	localparam int unsigned          RECIP_SHIFT = 19;
	localparam int unsigned          PROD_W      = YEAR_W + RECIP_W;
	localparam logic [YEAR_W-1:0]    CENTURY     = 14'd100;

	localparam logic [DAY_W-1:0] MONTH_DAYS [12] = '{
		5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
		5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
	};

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK            = 2'd0,
		STATUS_BAD_DATE      = 2'd1,
		STATUS_OUT_OF_LIMITS = 2'd2
	} status_t;

	// result of one month step
	typedef struct packed {
		logic                     done;
		logic [DAY_W-1:0]         dim;
		logic signed [WDAY_W-1:0] d;
		logic [MONTH_W-1:0]       m;
		logic signed [WYEAR_W-1:0] y;
		logic [REM_W-1:0]         r;
		logic [1:0]               c;
	} step_res_t;

	// leap year from y mod 4, y mod 100 and (y div 100) mod 4
	function automatic logic is_leap(input logic [1:0] ylo, input logic [REM_W-1:0] r,
			input logic [1:0] c);
		return (ylo == 2'd0) && ((r != '0) || (c == 2'd0));
	endfunction

	function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
			input logic leap);
		logic [DAY_W-1:0] len;
		priority if (m == MONTH_FEB && leap) begin
			len = LEAP_FEB_DAYS;
		end else if (m >= MONTH_JAN && m <= MONTH_DEC) begin
			len = MONTH_DAYS[m - MONTH_JAN];
		end else begin
			len = MONTH_DAYS[0];
		end
		return len;
	endfunction

endpackage

/* rtl/calendar_date_day_offset_unit.sv */
// calendar_date_day_offset_unit: gregorian date plus signed day offset, top level
// depends on cddo_pkg and cddo_step_unit
//
//  channel  | direction | payload
//  s_axis   | in        | tdata: day[4:0] month[8:5] year[22:9] offset_days[38:23]
//  m_axis   | out       | tdata: new_day[4:0] new_month[8:5] new_year[22:9]; tuser: status
//  cfg      | in        | cfg_index 0 min_year, 1 max_year; cfg_wdata 14 bits
//
// an item passes through accept, year split (divide, then remainder) and check, then, if
// the date is good, one walk step per month walked and a closing walk step, and waits in
// the output state until taken; the one month step unit is reused for every walk step.
// s_tready is high only while idle; one item is in flight at a time.
// the result is held in the output register until m_tready; reset clears the state and limit registers only.
module calendar_date_day_offset_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// day, month, year, offset_days from bit 0 up
	input  logic [cddo_pkg::S_TDATA_W-1:0]      s_tdata,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// new_day, new_month, new_year from bit 0 up
	output logic [cddo_pkg::M_TDATA_W-1:0]      m_tdata,
	// status
	output logic [cddo_pkg::STATUS_W-1:0]       m_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	input  logic                                cfg_we,
	input  logic                                cfg_index,
	input  logic [cddo_pkg::YEAR_W-1:0]         cfg_wdata
);
	import cddo_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_DIV   = 6'b000010,
		ST_REM   = 6'b000100,
		ST_CHECK = 6'b001000,
		ST_WALK  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t                    state_q;
	logic [YEAR_W-1:0]         min_year_q, max_year_q;
	logic [DAY_W-1:0]          day_q;
	logic signed [OFFSET_W-1:0] off_q;
	logic [MONTH_W-1:0]        m_q;
	logic signed [WYEAR_W-1:0] y_q;
	logic [CENT_W-1:0]         cent_q;
	logic [REM_W-1:0]          r_q;
	logic [1:0]                c_q;
	logic signed [WDAY_W-1:0]  d_q;
	logic [DAY_W-1:0]          out_day_q;
	logic [MONTH_W-1:0]        out_month_q;
	logic [YEAR_W-1:0]         out_year_q;
	status_t                   out_status_q;

	logic [PROD_W-1:0]         prod;
	logic [YEAR_W-1:0]         cent_x100;
	step_res_t                 st;
	logic                      in_bad, out_bad;
	logic signed [WYEAR_W-1:0] lo_s, hi_s;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_year_q <= MIN_YEAR_RST;
			max_year_q <= MAX_YEAR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_MIN_YEAR: min_year_q <= cfg_wdata;
				CFG_MAX_YEAR: max_year_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// year split into century and remainder
	assign prod      = {{RECIP_W{1'b0}}, y_q[YEAR_W-1:0]} * {{YEAR_W{1'b0}}, RECIP_100};
	assign cent_x100 = YEAR_W'({{(YEAR_W-CENT_W){1'b0}}, cent_q} * CENTURY);

	// shared month step unit
	cddo_step_unit u_step (
		.d   (d_q),
		.m   (m_q),
		.y   (y_q),
		.r   (r_q),
		.c   (c_q),
		.res (st)
	);

	// limit checks
	assign lo_s   = $signed({{(WYEAR_W-YEAR_W){1'b0}}, min_year_q});
	assign hi_s   = $signed({{(WYEAR_W-YEAR_W){1'b0}}, max_year_q});
	assign in_bad = (y_q < lo_s) || (y_q > hi_s) || (m_q < MONTH_JAN) || (m_q > MONTH_DEC)
		|| (day_q == '0) || (day_q > st.dim);
	assign out_bad = (y_q < lo_s) || (y_q > hi_s);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (s_tvalid) state_q <= ST_DIV;
				ST_DIV:   state_q <= ST_REM;
				ST_REM:   state_q <= ST_CHECK;
				ST_CHECK: state_q <= in_bad ? ST_OUT : ST_WALK;
				ST_WALK:  if (st.done) state_q <= ST_OUT;
				ST_OUT:   if (m_tready) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				day_q <= s_tdata[4:0];
				m_q   <= s_tdata[8:5];
				y_q   <= $signed({{(WYEAR_W-YEAR_W){1'b0}}, s_tdata[22:9]});
				off_q <= s_tdata[38:23];
			end
			ST_DIV: begin
				cent_q <= prod[RECIP_SHIFT +: CENT_W];
			end
			ST_REM: begin
				r_q <= REM_W'(y_q[YEAR_W-1:0] - cent_x100);
				c_q <= cent_q[1:0];
			end
			ST_CHECK: begin
				d_q <= $signed({{(WDAY_W-DAY_W){1'b0}}, day_q})
					+ $signed({off_q[OFFSET_W-1], off_q});
				if (in_bad) begin
					out_day_q    <= '0;
					out_month_q  <= '0;
					out_year_q   <= '0;
					out_status_q <= STATUS_BAD_DATE;
				end
			end
			ST_WALK: begin
				d_q <= st.d;
				m_q <= st.m;
				y_q <= st.y;
				r_q <= st.r;
				c_q <= st.c;
				if (st.done) begin
					if (out_bad) begin
						out_day_q    <= '0;
						out_month_q  <= '0;
						out_year_q   <= '0;
						out_status_q <= STATUS_OUT_OF_LIMITS;
					end else begin
						out_day_q    <= d_q[DAY_W-1:0];
						out_month_q  <= m_q;
						out_year_q   <= y_q[YEAR_W-1:0];
						out_status_q <= STATUS_OK;
					end
				end
			end
			ST_OUT: ;
			default: ;
		endcase
	end

	// stream ports
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {1'b0, out_year_q, out_month_q, out_day_q};
	assign m_tuser  = out_status_q;

endmodule

/* rtl/cddo_step_unit.sv */
// cddo_step_unit: one month step of the day walk, forward carry or backward borrow
// depends on cddo_pkg
module cddo_step_unit (
	input  logic signed [cddo_pkg::WDAY_W-1:0]  d,
	input  logic [cddo_pkg::MONTH_W-1:0]        m,
	input  logic signed [cddo_pkg::WYEAR_W-1:0] y,
	input  logic [cddo_pkg::REM_W-1:0]          r,
	input  logic [1:0]                          c,
	output cddo_pkg::step_res_t                 res
);
	import cddo_pkg::*;

	logic                     leap_cur, leap_prev, wrap_b, fwd, bwd;
	logic [DAY_W-1:0]         dim_cur, dim_prev;
	logic [MONTH_W-1:0]       pm;
	logic [REM_W-1:0]         pr;
	logic [1:0]               pc;
	logic signed [WDAY_W-1:0] addend;
	logic signed [WYEAR_W-1:0] y_adj;

	// length of the current month
	assign leap_cur = is_leap(y[1:0], r, c);
	assign dim_cur  = month_len(m, leap_cur);

	// previous month, with year borrow in january
	assign wrap_b    = (m == MONTH_JAN);
	assign pm        = wrap_b ? MONTH_DEC : (m - 4'd1);
	assign pr        = (r == '0) ? REM_MAX : (r - 7'd1);
	assign pc        = (r == '0) ? (c - 2'd1) : c;
	assign leap_prev = wrap_b ? is_leap(y[1:0] - 2'd1, pr, pc) : leap_cur;
	assign dim_prev  = month_len(pm, leap_prev);

	// direction
	assign fwd = d > $signed({{(WDAY_W-DAY_W){1'b0}}, dim_cur});
	assign bwd = d < $signed(WDAY_W'(1));

	// one shared day adder and one shared year adder
	assign addend = fwd ? -$signed({{(WDAY_W-DAY_W){1'b0}}, dim_cur})
		: $signed({{(WDAY_W-DAY_W){1'b0}}, dim_prev});
	assign y_adj  = y + (fwd ? $signed(WYEAR_W'(1)) : -$signed(WYEAR_W'(1)));

	always_comb begin
		res.done = !fwd && !bwd;
		res.dim  = dim_cur;
		res.d    = d;
		res.m    = m;
		res.y    = y;
		res.r    = r;
		res.c    = c;
		priority if (fwd) begin
			res.d = d + addend;
			if (m == MONTH_DEC) begin
				res.m = MONTH_JAN;
				res.y = y_adj;
				res.r = (r == REM_MAX) ? '0 : (r + 7'd1);
				res.c = (r == REM_MAX) ? (c + 2'd1) : c;
			end else begin
				res.m = m + 4'd1;
			end
		end else if (bwd) begin
			res.d = d + addend;
			res.m = pm;
			if (wrap_b) begin
				res.y = y_adj;
				res.r = pr;
				res.c = pc;
			end
		end
	end

endmodule

/* rtl/cddo_checker.sv */
// cddo_checker: port-level checks of the date offset unit, bound to the top level
// depends on cddo_pkg and calendar_date_day_offset_unit
module cddo_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           s_tvalid,
	input logic                           s_tready,
	input logic [cddo_pkg::M_TDATA_W-1:0] m_tdata,
	input logic [cddo_pkg::STATUS_W-1:0]  m_tuser,
	input logic                           m_tvalid,
	input logic                           m_tready
);
	import cddo_pkg::*;

	// one item in flight: no new item while a result is offered
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		!(s_tready && m_tvalid))
		else $error("input ready while result pending");

	// an accepted item closes the input side
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input ready right after accept");

	// error results carry an all-zero date
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser != STATUS_OK) |-> (m_tdata == '0))
		else $error("error result with nonzero date");

	// good results carry a real month and day
	a_ok_date: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser == STATUS_OK) |->
		(m_tdata[8:5] != 4'd0 && m_tdata[8:5] <= MONTH_DEC && m_tdata[4:0] != 5'd0))
		else $error("ok result with bad month or day");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("result changed while stalled");

endmodule

bind calendar_date_day_offset_unit cddo_checker u_cddo_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready)
);

/* bench/testbench.sv */
// testbench for calendar_date_day_offset_unit: directed calendar cases, then random dates
// under several year-limit settings and handshake idling modes, scored on the fly
// depends on cddo_pkg and the rtl of the date offset unit
module testbench;
	import cddo_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int DRAIN_CYCLES = 20;

	typedef struct {
		logic [DAY_W-1:0]           day;
		logic [MONTH_W-1:0]         month;
		logic [YEAR_W-1:0]          year;
		logic signed [OFFSET_W-1:0] offset;
	} date_in_t;

	typedef struct {
		logic [DAY_W-1:0]   day;
		logic [MONTH_W-1:0] month;
		logic [YEAR_W-1:0]  year;
		status_t            status;
	} date_out_t;

	typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic [S_TDATA_W-1:0]   s_tdata;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic [STATUS_W-1:0]    m_tuser;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic                   cfg_we;
	logic                   cfg_index;
	logic [YEAR_W-1:0]      cfg_wdata;

	// local copy of the year limit registers
	int lo_year = MIN_YEAR_RST;
	int hi_year = MAX_YEAR_RST;

	date_out_t due_dates[$];
	date_out_t want_date;
	int send_idle_pct;
	int recv_stall_pct;
	int items_sent;
	int results_seen = 0;
	int limit_settings;
	int mismatches = 0;
	int idle_cycles = 0;

	calendar_date_day_offset_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// gregorian leap rule, remainder truncates toward zero for negative years
	function automatic bit leap_year(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic int month_length(input int m, input int y);
		if (m == MONTH_FEB)
			return leap_year(y) ? 29 : 28;
		if (m == 4 || m == 6 || m == 9 || m == 11)
			return 30;
		return 31;
	endfunction

	// expected result of adding a day offset to a date under the current limits
	function automatic date_out_t shift_date(input date_in_t it);
		date_out_t r;
		int d, m, y;
		d = it.day;
		m = it.month;
		y = it.year;
		r.day = '0;
		r.month = '0;
		r.year = '0;
		r.status = STATUS_OK;
		if (y < lo_year || y > hi_year || m < MONTH_JAN || m > MONTH_DEC || d < 1
				|| d > month_length(m, y)) begin
			r.status = STATUS_BAD_DATE;
			return r;
		end
		d += int'(it.offset);
		// carry forward through whole months
		while (d > month_length(m, y)) begin
			d -= month_length(m, y);
			m++;
			if (m > MONTH_DEC) begin
				m = MONTH_JAN;
				y++;
			end
		end
		// borrow the previous month going backward
		while (d < 1) begin
			m--;
			if (m < MONTH_JAN) begin
				m = MONTH_DEC;
				y--;
			end
			d += month_length(m, y);
		end
		if (y < lo_year || y > hi_year) begin
			r.status = STATUS_OUT_OF_LIMITS;
			return r;
		end
		r.day = DAY_W'(d);
		r.month = MONTH_W'(m);
		r.year = YEAR_W'(y);
		return r;
	endfunction

	function automatic date_in_t make_date(input int d, input int m, input int y, input int off);
		date_in_t it;
		it.day = DAY_W'(d);
		it.month = MONTH_W'(m);
		it.year = YEAR_W'(y);
		it.offset = OFFSET_W'(off);
		return it;
	endfunction

	// mostly well-formed dates inside the limits, some raw noise
	function automatic date_in_t random_date();
		date_in_t it;
		int pick, len, y_lo, y_hi;
		y_lo = (lo_year <= hi_year) ? lo_year : hi_year;
		y_hi = (lo_year <= hi_year) ? hi_year : lo_year;
		pick = $urandom_range(99);
		if (pick < 12) begin
			it.day = DAY_W'($urandom);
			it.month = MONTH_W'($urandom);
			it.year = YEAR_W'($urandom);
			it.offset = OFFSET_W'($urandom);
			return it;
		end
		it.year = YEAR_W'($urandom_range(y_hi, y_lo));
		it.month = MONTH_W'($urandom_range(12, 1));
		len = month_length(it.month, it.year);
		it.day = DAY_W'($urandom_range(len, 1));
		pick = $urandom_range(99);
		if (pick < 15) begin
			// month and year edges with tiny steps
			it.day = DAY_W'($urandom_range(1) ? len : 1);
			it.offset = OFFSET_W'(int'($urandom_range(6)) - 3);
		end else if (pick < 65) begin
			it.offset = OFFSET_W'(int'($urandom_range(800)) - 400);
		end else if (pick < 90) begin
			it.offset = OFFSET_W'(int'($urandom_range(10000)) - 5000);
		end else begin
			it.offset = OFFSET_W'($urandom);
		end
		return it;
	endfunction

	task automatic flag_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at result %0d, %s: got %0d, expected %0d",
			results_seen, what, got, want);
	endtask

	task automatic set_idling(input idle_mode_t mode);
		send_idle_pct = (mode == IDLE_SEND) ? 61 : (mode == IDLE_BOTH) ? 35 : 0;
		recv_stall_pct = (mode == IDLE_RECV) ? 61 : (mode == IDLE_BOTH) ? 35 : 0;
	endtask

	// present one item and hold it until taken, then log its expected result
	task automatic send_date(input date_in_t it);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tdata <= {1'b0, it.offset, it.year, it.month, it.day};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		due_dates.push_back(shift_date(it));
		items_sent++;
	endtask

	// sender holds off until every pending result has come back
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		while (due_dates.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_year_limits(input int lo, input int hi);
		wait_for_results();
		cfg_we <= 1'b1;
		cfg_index <= CFG_MIN_YEAR;
		cfg_wdata <= YEAR_W'(lo);
		@(posedge clk);
		cfg_index <= CFG_MAX_YEAR;
		cfg_wdata <= YEAR_W'(hi);
		@(posedge clk);
		cfg_we <= 1'b0;
		lo_year = lo & 16'h3fff;
		hi_year = hi & 16'h3fff;
		limit_settings++;
		@(posedge clk);
	endtask

	task automatic run_random_phase(input int lo, input int hi, input idle_mode_t mode,
			input int count, input bit pause_midway);
		write_year_limits(lo, hi);
		set_idling(mode);
		for (int i = 0; i < count; i++) begin
			if (pause_midway && i == count / 2)
				wait_for_results();
			send_date(random_date());
		end
	endtask

	// limits straight out of reset, edges of the default window
	task automatic test_reset_limits();
		set_idling(IDLE_NONE);
		send_date(make_date(1, 1, 1902, 0));
		send_date(make_date(1, 1, 1902, -1));
		send_date(make_date(31, 12, 2037, 1));
		send_date(make_date(31, 12, 1901, 0));
		send_date(make_date(1, 1, 2038, 0));
		send_date(make_date(29, 2, 2000, 365));
	endtask

	// leap rules, malformed dates and field extremes with the widest limits
	task automatic test_calendar_rules();
		write_year_limits(0, 16383);
		send_date(make_date(29, 2, 2000, 0));
		send_date(make_date(29, 2, 1900, 0));
		send_date(make_date(29, 2, 2100, 0));
		send_date(make_date(29, 2, 2024, 1));
		send_date(make_date(29, 2, 2023, 0));
		send_date(make_date(0, 3, 2023, 5));
		send_date(make_date(31, 4, 2023, 0));
		send_date(make_date(1, 0, 2023, 0));
		send_date(make_date(1, 13, 2023, 0));
		send_date(make_date(31, 15, 16383, -32768));
		send_date(make_date(31, 12, 16383, 1));
		send_date(make_date(1, 1, 0, -1));
		send_date(make_date(1, 1, 0, 32767));
		send_date(make_date(31, 12, 9999, -32768));
		send_date(make_date(1, 3, 2000, -1));
		send_date(make_date(1, 3, 1900, -1));
		send_date(make_date(1, 1, 2000, 32767));
	endtask

	task automatic test_random_traffic();
		int a, b;
		run_random_phase(MIN_YEAR_RST, MAX_YEAR_RST, IDLE_NONE, 90, 1'b0);
		run_random_phase(0, 16383, IDLE_SEND, 90, 1'b0);
		run_random_phase(0, 9999, IDLE_RECV, 90, 1'b1);
		a = $urandom_range(16383);
		b = $urandom_range(16383);
		run_random_phase(a < b ? a : b, a < b ? b : a, IDLE_BOTH, 90, 1'b0);
	endtask

	// min above max rejects every date
	task automatic test_crossed_limits();
		run_random_phase(2000, 1999, IDLE_BOTH, 30, 1'b0);
	endtask

	// one-year window, most walks leave it; then the default window again
	task automatic test_single_year();
		run_random_phase(2000, 2000, IDLE_BOTH, 60, 1'b0);
		run_random_phase(MIN_YEAR_RST, MAX_YEAR_RST, IDLE_BOTH, 90, 1'b0);
	endtask

	// receiver side ready pattern
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_stall_pct);

	// score each result against the oldest pending expectation
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (due_dates.size() == 0) begin
				flag_mismatch("result with nothing pending", m_tuser, 0);
			end else begin
				want_date = due_dates.pop_front();
				if (m_tdata[4:0] != want_date.day)
					flag_mismatch("new_day", m_tdata[4:0], want_date.day);
				if (m_tdata[8:5] != want_date.month)
					flag_mismatch("new_month", m_tdata[8:5], want_date.month);
				if (m_tdata[22:9] != want_date.year)
					flag_mismatch("new_year", m_tdata[22:9], want_date.year);
				if (m_tuser != want_date.status)
					flag_mismatch("status", m_tuser, want_date.status);
			end
		end
	end

	// watchdog on cycles with no traffic of any kind
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("watchdog: no traffic for %0d cycles, %0d results pending",
				idle_cycles, due_dates.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		s_tdata = '0;
		s_tvalid = 1'b0;
		cfg_we = 1'b0;
		cfg_index = CFG_MIN_YEAR;
		cfg_wdata = '0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		items_sent = 0;
		limit_settings = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_limits();
		test_calendar_rules();
		test_random_traffic();
		test_crossed_limits();
		test_single_year();

		wait_for_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("testbench: %0d dates sent over %0d year-limit settings, %0d results scored",
			items_sent, limit_settings, results_seen);
		$display("testbench: %0d mismatches, %0d results left pending",
			mismatches, due_dates.size());
		if (mismatches == 0 && due_dates.size() == 0)
			$display("testbench: done, clean");
		else
			$display("testbench: done, errors");
		$finish;
	end

endmodule
